@@ rtl/cau_pkg.sv @@
// Package for the complex arithmetic unit: opcodes, status codes, FSM states,
// CORDIC arctangent table. No dependencies.
package cau_pkg;

    localparam int DataWidthDef   = 16;
    localparam int FracBitsDef    = 12;
    localparam int MaxExponentDef = 15;
    localparam int CordicSteps    = 31;
    localparam int AngleFrac      = 30;
    localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_ABS  = 3'd5,
        OP_ARG  = 3'd6,
        OP_POW  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ITER,
        S_FINISH,
        S_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic finish;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic last;
    } t_dp_status;

    // Arctangent of 2^-i in units of 2^-30 rad.
    function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
        logic signed [63:0] v;
        begin
            case (i)
                5'd0:    v = 64'sd843314857;
                5'd1:    v = 64'sd497837829;
                5'd2:    v = 64'sd263043837;
                5'd3:    v = 64'sd133525159;
                5'd4:    v = 64'sd67021687;
                5'd5:    v = 64'sd33543516;
                5'd6:    v = 64'sd16775851;
                5'd7:    v = 64'sd8388437;
                5'd8:    v = 64'sd4194283;
                5'd9:    v = 64'sd2097149;
                default: v = 64'sd1 <<< (5'd30 - i);
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/cau_if.sv @@
// Valid/ready stream interface for the complex arithmetic unit.
// Depends on nothing; payload type given as a parameter.
interface cau_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/complex_arithmetic_unit.sv @@
// Channel   Dir  Payload
// in        in   operation, a_real, a_imag, b_real, b_imag, exponent
// out       out  res_real, res_imag, status
//
// Each item passes load, prep, N iteration steps, finish, output. N is set by
// the engine: 48 restoring divide steps (2*DATA_WIDTH + FRAC_BITS + 4), 17
// square root, 31 CORDIC or exponent-1 power multiplies (at least one step); one step
// for the other ops. Reset clears the controller only. A stalled result holds in
// the output register; the next item is taken in the cycle its result transfers.
// Top level of the complex arithmetic unit. Depends on cau_pkg, cau_ctrl and
// cau_dp.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH   = DataWidthDef,
    parameter int FRAC_BITS    = FracBitsDef,
    parameter int MAX_EXPONENT = MaxExponentDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_a_real,
    input  logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [DATA_WIDTH-1:0] i_b_real,
    input  logic signed [DATA_WIDTH-1:0] i_b_imag,
    input  logic [3:0]                   i_exponent,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_real,
    output logic signed [DATA_WIDTH-1:0] o_res_imag,
    output logic [1:0]                   o_status
);

    t_cmd       w_cmd;
    t_dp_status w_dps;

    // Sequencer.
    cau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .o_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_dp       (w_dps),
        .o_cmd      (w_cmd)
    );

    // Arithmetic.
    cau_dp #(
        .DATA_WIDTH  (DATA_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .MAX_EXPONENT(MAX_EXPONENT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_op    (i_operation),
        .i_ar    (i_a_real),
        .i_ai    (i_a_imag),
        .i_br    (i_b_real),
        .i_bi    (i_b_imag),
        .i_exp   (i_exponent),
        .o_status(w_dps),
        .o_rr    (o_res_real),
        .o_ri    (o_res_imag),
        .o_st    (o_status)
    );

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_real) && $stable(o_status))
        else $error("result dropped under stall");
    a_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !o_valid |-> !$past(o_valid) || $past(i_ready))
        else $error("idle without transfer");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
`endif

endmodule

@@ rtl/cau_ctrl.sv @@
// Controller state machine for the complex arithmetic unit.
// Depends on cau_pkg.
module cau_ctrl
    import cau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_dp,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP:   n_state = S_ITER;
            S_ITER: begin
                if (i_dp.last) n_state = S_FINISH;
            end
            S_FINISH: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = i_in_valid ? S_PREP : S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs. A new item is taken in the same cycle the result leaves.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PREP:   o_cmd.prep = 1'b1;
            S_ITER:   o_cmd.step = 1'b1;
            S_FINISH: o_cmd.finish = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                o_cmd.load  = i_out_ready && i_in_valid;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> o_in_ready && i_in_valid) else $error("load without transfer");
    a_no_dual_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.prep, o_cmd.step, o_cmd.finish, o_out_valid}))
        else $error("overlapping commands");
    a_load_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.prep) else $error("load not followed by prep");
`endif

endmodule

@@ rtl/cau_dp.sv @@
// Datapath of the complex arithmetic unit: shared iteration engine for
// divide, square root, CORDIC and power chain. Depends on cau_pkg.
module cau_dp
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH   = DataWidthDef,
    parameter int FRAC_BITS    = FracBitsDef,
    parameter int MAX_EXPONENT = MaxExponentDef
) (
    input  logic                         i_clk,
    input  t_cmd                         i_cmd,
    input  logic [2:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_ar,
    input  logic signed [DATA_WIDTH-1:0] i_ai,
    input  logic signed [DATA_WIDTH-1:0] i_br,
    input  logic signed [DATA_WIDTH-1:0] i_bi,
    input  logic [3:0]                   i_exp,
    output t_dp_status                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_rr,
    output logic signed [DATA_WIDTH-1:0] o_ri,
    output logic [1:0]                   o_st
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W + 2;     // products and sums of products
    localparam int QW  = PW + FRAC_BITS + 2;
    localparam int DivSteps  = QW;
    localparam int SqrtSteps = W + 1;
    localparam int CntMax    = (DivSteps > MAX_EXPONENT) ? DivSteps : MAX_EXPONENT;
    localparam int CntW      = $clog2(CntMax + 1);
    localparam logic signed [63:0] Lim    = 64'sd1 <<< (W - 1);
    localparam logic signed [63:0] PosMax = Lim - 64'sd1;
    localparam logic signed [63:0] NegMin = -Lim;
    localparam int ExpW = $clog2(MAX_EXPONENT + 1);

    // Round a signed value to nearest (ties away) dropping s bits.
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int s);
        logic [63:0] m;
        begin
            m = v[63] ? 64'(-v) : 64'(v);
            m = (m + (64'd1 << (s - 1))) >> s;
            return v[63] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic sat_flag(input logic signed [63:0] v);
        return (v > PosMax) || (v < NegMin);
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = (v > PosMax) ? PosMax : ((v < NegMin) ? NegMin : v);
            return t[W-1:0];
        end
    endfunction

    // Operand and working registers.
    logic [2:0]            r_op;
    logic signed [W-1:0]   r_ar, r_ai, r_br, r_bi;
    logic [ExpW-1:0]       r_n;
    logic [CntW-1:0]       r_cnt;
    logic                  r_sat, r_dz;
    logic signed [W-1:0]   r_pr, r_pi;          // power chain accumulator
    logic signed [63:0]    r_x, r_y, r_z;       // CORDIC
    logic [QW-1:0]         r_numr, r_numi;      // divide numerator magnitudes
    logic                  r_negr, r_negi;
    logic [QW-1:0]         r_qr, r_qi, r_remr, r_remi;
    logic [PW-1:0]         r_den;
    logic [PW-1:0]         r_sv, r_sres, r_sbit; // square root
    logic [CntW-1:0]       r_last_cnt;
    logic signed [W-1:0]   r_rr, r_ri;
    logic [1:0]            r_st;

    // One complex multiply of a by the power accumulator, rounded.
    logic signed [63:0] m_re, m_im, m_rre, m_rim;
    always_comb begin
        m_re  = 64'(r_ar) * 64'(r_pr) - 64'(r_ai) * 64'(r_pi);
        m_im  = 64'(r_ar) * 64'(r_pi) + 64'(r_ai) * 64'(r_pr);
        m_rre = rnd(m_re, FRAC_BITS);
        m_rim = rnd(m_im, FRAC_BITS);
    end

    // One restoring divide step for each half.
    logic [QW:0] d_tr, d_ti;
    always_comb begin
        d_tr = {r_remr, r_numr[QW-1]};
        d_ti = {r_remi, r_numi[QW-1]};
    end

    // CORDIC shifts; arithmetic shift floors.
    logic signed [63:0] c_dx, c_dy;
    always_comb begin
        c_dx = r_y >>> r_cnt[4:0];
        c_dy = r_x >>> r_cnt[4:0];
    end

    assign o_status.last = (r_cnt == r_last_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_ar <= i_ar;
            r_ai <= i_ai;
            r_br <= i_br;
            r_bi <= i_bi;
            r_n  <= (int'(i_exp) > MAX_EXPONENT) ? ExpW'(MAX_EXPONENT) : ExpW'(i_exp);
        end
        // Set up the iteration for the operation.
        if (i_cmd.prep) begin
            logic signed [63:0] nr, ni, den, sx, sy;
            nr  = 64'(r_ar) * 64'(r_br) + 64'(r_ai) * 64'(r_bi);
            ni  = 64'(r_ai) * 64'(r_br) - 64'(r_ar) * 64'(r_bi);
            den = 64'(r_br) * 64'(r_br) + 64'(r_bi) * 64'(r_bi);
            r_sat  <= 1'b0;
            r_dz   <= 1'b0;
            r_cnt  <= '0;
            r_last_cnt <= '0;
            r_pr   <= r_ar;
            r_pi   <= r_ai;
            r_negr <= nr[63];
            r_negi <= ni[63];
            r_numr <= QW'(nr[63] ? -nr : nr) << (FRAC_BITS + 1);
            r_numi <= QW'(ni[63] ? -ni : ni) << (FRAC_BITS + 1);
            r_remr <= '0;
            r_remi <= '0;
            r_qr   <= '0;
            r_qi   <= '0;
            r_den  <= PW'(den);
            r_sv   <= PW'(64'(r_ar) * 64'(r_ar) + 64'(r_ai) * 64'(r_ai));
            r_sres <= '0;
            r_sbit <= PW'(1) << (2 * ((PW - 1) / 2));
            sx = 64'(r_ar) <<< (40 - W);
            sy = 64'(r_ai) <<< (40 - W);
            if (sx < 0) begin
                if (sy >= 0) begin
                    r_x <= sy; r_y <= -sx; r_z <= HalfPiQ30;
                end else begin
                    r_x <= -sy; r_y <= sx; r_z <= -HalfPiQ30;
                end
            end else begin
                r_x <= sx; r_y <= sy; r_z <= '0;
            end
            case (r_op)
                OP_DIV:  r_last_cnt <= CntW'(DivSteps - 1);
                OP_ABS:  r_last_cnt <= CntW'(SqrtSteps - 1);
                OP_ARG:  r_last_cnt <= CntW'(CordicSteps - 1);
                OP_POW:  r_last_cnt <= (r_n > 1) ? CntW'(r_n - 2) : '0;
                default: r_last_cnt <= '0;
            endcase
            if (r_op == OP_DIV && den == 0) r_dz <= 1'b1;
        end
        // One iteration of the selected engine.
        if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
            case (r_op)
                OP_DIV: begin
                    r_numr <= r_numr << 1;
                    r_numi <= r_numi << 1;
                    if (d_tr >= {1'b0, QW'(r_den)}) begin
                        r_remr <= QW'(d_tr - {1'b0, QW'(r_den)});
                        r_qr   <= {r_qr[QW-2:0], 1'b1};
                    end else begin
                        r_remr <= QW'(d_tr);
                        r_qr   <= {r_qr[QW-2:0], 1'b0};
                    end
                    if (d_ti >= {1'b0, QW'(r_den)}) begin
                        r_remi <= QW'(d_ti - {1'b0, QW'(r_den)});
                        r_qi   <= {r_qi[QW-2:0], 1'b1};
                    end else begin
                        r_remi <= QW'(d_ti);
                        r_qi   <= {r_qi[QW-2:0], 1'b0};
                    end
                end
                OP_ABS: begin
                    if (r_sbit != 0) begin
                        if (r_sv >= r_sres + r_sbit) begin
                            r_sv   <= r_sv - (r_sres + r_sbit);
                            r_sres <= (r_sres >> 1) + r_sbit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end
                OP_ARG: begin
                    if (!r_y[63]) begin
                        r_x <= r_x + c_dx;
                        r_y <= r_y - c_dy;
                        r_z <= r_z + atan_q30(r_cnt[4:0]);
                    end else begin
                        r_x <= r_x - c_dx;
                        r_y <= r_y + c_dy;
                        r_z <= r_z - atan_q30(r_cnt[4:0]);
                    end
                end
                OP_POW: begin
                    if (r_n > 1) begin
                        r_pr <= sat(m_rre);
                        r_pi <= sat(m_rim);
                        if (sat_flag(m_rre) || sat_flag(m_rim)) r_sat <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // Form the final result.
        if (i_cmd.finish) begin
            logic signed [63:0] t0, t1, qa, qb;
            logic s;
            t0 = '0; t1 = '0; s = r_sat;
            qa = $signed(64'((r_qr + 1'b1) >> 1));
            qb = $signed(64'((r_qi + 1'b1) >> 1));
            case (r_op)
                OP_ADD: begin
                    t0 = 64'(r_ar) + 64'(r_br); t1 = 64'(r_ai) + 64'(r_bi);
                end
                OP_SUB: begin
                    t0 = 64'(r_ar) - 64'(r_br); t1 = 64'(r_ai) - 64'(r_bi);
                end
                OP_MUL: begin
                    t0 = rnd(64'(r_ar) * 64'(r_br) - 64'(r_ai) * 64'(r_bi), FRAC_BITS);
                    t1 = rnd(64'(r_ar) * 64'(r_bi) + 64'(r_ai) * 64'(r_br), FRAC_BITS);
                end
                OP_DIV: begin
                    t0 = r_negr ? -qa : qa; t1 = r_negi ? -qb : qb;
                    if (r_dz) begin t0 = '0; t1 = '0; end
                end
                OP_CONJ: begin t0 = 64'(r_ar); t1 = -64'(r_ai); end
                OP_ABS:  t0 = 64'((r_sv > r_sres) ? r_sres + 1'b1 : r_sres);
                OP_ARG: begin
                    if (r_ar != 0 || r_ai != 0) t0 = rnd(r_z, AngleFrac - FRAC_BITS);
                end
                default: begin
                    if (r_n == 0) t0 = 64'sd1 <<< FRAC_BITS;
                    else begin t0 = 64'(r_pr); t1 = 64'(r_pi); end
                end
            endcase
            if (sat_flag(t0) || sat_flag(t1)) s = 1'b1;
            r_rr <= sat(t0);
            r_ri <= sat(t1);
            r_st <= r_dz ? ST_DIVZ : (s ? ST_SAT : ST_OK);
        end
    end

    assign o_rr = r_rr;
    assign o_ri = r_ri;
    assign o_st = r_st;

`ifndef ASSERT_OFF
    a_dz_only_div: assert property (@(posedge i_clk)
        i_cmd.finish && r_dz |-> r_op == OP_DIV) else $error("divide flag on other op");
    a_cnt_bound: assert property (@(posedge i_clk)
        i_cmd.step |-> r_cnt <= r_last_cnt) else $error("iteration overran");
    a_finish_after: assert property (@(posedge i_clk)
        i_cmd.finish |-> $past(i_cmd.step)) else $error("finish without iteration");
`endif

endmodule

@@ verif/tb_cau_pkg.sv @@
`timescale 1ns / 1ps
// Transfer payload types for the complex arithmetic unit testbench.
// Depends on cau_pkg for the opcode type.
package tb_cau_pkg;
    import cau_pkg::*;

    typedef struct packed {
        t_op                operation;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
        logic signed [15:0] b_real;
        logic signed [15:0] b_imag;
        logic [3:0]         exponent;
    } t_cau_req;

    typedef struct packed {
        logic signed [15:0] res_real;
        logic signed [15:0] res_imag;
        logic [1:0]         status;
    } t_cau_rsp;
endpackage

@@ verif/cau_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the complex arithmetic unit: watches both channels,
// predicts each result in fixed point and compares. Depends on cau_pkg,
// tb_cau_pkg and cau_if.
module cau_checker
    import cau_pkg::*;
    import tb_cau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cau_if       in_ch,
    cau_if       out_ch,
    output int   o_pending,
    output int   o_errors
);

    localparam int  FracBits = 12;
    localparam int  MaxExp   = 15;
    localparam longint MaxVal = 32767;
    localparam longint MinVal = -32768;
    localparam longint HalfPi = 1686629713;

    // Arctangent of 2^-i in units of 2^-30 rad.
    localparam longint AtanRad[31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1
    };

    t_cau_rsp expected_results[$];

    // Round to nearest with ties away from zero, dropping s fraction bits.
    function automatic longint round_away(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip16(longint v, inout bit sat);
        if (v > MaxVal) begin
            sat = 1;
            return MaxVal;
        end
        if (v < MinVal) begin
            sat = 1;
            return MinVal;
        end
        return v;
    endfunction

    function automatic void cplx_mul(longint ar, longint ai, longint br, longint bi,
                                     output longint rr, output longint ri,
                                     inout bit sat);
        rr = clip16(round_away(ar * br - ai * bi, FracBits), sat);
        ri = clip16(round_away(ar * bi + ai * br, FracBits), sat);
    endfunction

    // Restoring division with one guard bit, then round half up on magnitude.
    function automatic longint frac_div(longint num, longint den, inout bit sat);
        longint mag;
        longint q0;
        longint rem;
        longint qf;
        mag = (num < 0) ? -num : num;
        q0  = mag / den;
        rem = mag % den;
        if (q0 > 65536)
            return clip16((num < 0) ? -64'sd1 <<< 40 : 64'sd1 <<< 40, sat);
        qf = q0;
        for (int i = 0; i < FracBits + 1; i++) begin
            rem = rem << 1;
            qf  = qf << 1;
            if (rem >= den) begin
                rem = rem - den;
                qf  = qf | 1;
            end
        end
        qf = (qf + 1) >> 1;
        return clip16((num < 0) ? -qf : qf, sat);
    endfunction

    function automatic longint sqrt_nearest(longint v);
        longint res;
        longint bitv;
        res  = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return (v > res) ? res + 1 : res;
    endfunction

    // Vectoring CORDIC with quarter-turn pre-rotation; angle in Q.30 radians.
    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        x = x <<< 24;
        y = y <<< 24;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = HalfPi;
            end else begin
                x = -y;
                y = t;
                z = -HalfPi;
            end
        end
        for (int i = 0; i < 31; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + AtanRad[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - AtanRad[i];
            end
        end
        return z;
    endfunction

    function automatic t_cau_rsp predict_complex_op(t_cau_req req);
        longint   ar;
        longint   ai;
        longint   br;
        longint   bi;
        longint   rr;
        longint   ri;
        longint   tr;
        longint   ti;
        longint   den;
        int       n;
        bit       sat;
        bit       divz;
        t_cau_rsp rsp;
        ar   = req.a_real;
        ai   = req.a_imag;
        br   = req.b_real;
        bi   = req.b_imag;
        n    = req.exponent;
        rr   = 0;
        ri   = 0;
        sat  = 0;
        divz = 0;
        case (req.operation)
            OP_ADD: begin
                rr = clip16(ar + br, sat);
                ri = clip16(ai + bi, sat);
            end
            OP_SUB: begin
                rr = clip16(ar - br, sat);
                ri = clip16(ai - bi, sat);
            end
            OP_MUL: cplx_mul(ar, ai, br, bi, rr, ri, sat);
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    divz = 1;
                end else begin
                    rr = frac_div(ar * br + ai * bi, den, sat);
                    ri = frac_div(ai * br - ar * bi, den, sat);
                end
            end
            OP_CONJ: begin
                rr = ar;
                ri = clip16(-ai, sat);
            end
            OP_ABS: rr = clip16(sqrt_nearest(ar * ar + ai * ai), sat);
            OP_ARG: begin
                if (ar != 0 || ai != 0)
                    rr = clip16(round_away(vector_angle(ar, ai), 30 - FracBits), sat);
            end
            default: begin
                if (n > MaxExp) n = MaxExp;
                if (n == 0) begin
                    rr = clip16(64'sd1 <<< FracBits, sat);
                end else begin
                    rr = ar;
                    ri = ai;
                    for (int k = 1; k < n; k++) begin
                        cplx_mul(ar, ai, rr, ri, tr, ti, sat);
                        rr = tr;
                        ri = ti;
                    end
                end
            end
        endcase
        rsp.res_real = rr[15:0];
        rsp.res_imag = ri[15:0];
        rsp.status   = divz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
        return rsp;
    endfunction

    assign o_pending = expected_results.size();

    // Predict on each accepted operand transfer, compare on each result transfer.
    always @(posedge i_clk) begin
        t_cau_rsp want;
        t_cau_rsp got;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_complex_op(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: real %0d imag %0d status %0d",
                           got.res_real, got.res_imag, got.status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.res_real !== want.res_real ||
                        got.res_imag !== want.res_imag ||
                        got.status !== want.status)
                        o_errors <= o_errors + 1;
                    if (got.res_real !== want.res_real)
                        $error("res_real: expected %0d, got %0d",
                               want.res_real, got.res_real);
                    if (got.res_imag !== want.res_imag)
                        $error("res_imag: expected %0d, got %0d",
                               want.res_imag, got.res_imag);
                    if (got.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, got.status);
                end
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the complex arithmetic unit testbench: clock, reset, operand stimulus,
// result back-pressure and verdict. Depends on cau_pkg, tb_cau_pkg, cau_if,
// cau_checker and the unit itself.
module tb_top;
    import cau_pkg::*;
    import tb_cau_pkg::*;

    localparam int NumRandom = 1500;
    localparam int CycleLimit = 2000000;

    logic i_clk;
    logic i_rst_n;
    int   pending_results;
    int   error_count;
    int   cycle_count;
    bit   quiet_phase;

    cau_if #(.T(t_cau_req)) in_ch ();
    cau_if #(.T(t_cau_rsp)) out_ch ();

    complex_arithmetic_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_ch.valid),
        .o_ready    (in_ch.ready),
        .i_operation(in_ch.data.operation),
        .i_a_real   (in_ch.data.a_real),
        .i_a_imag   (in_ch.data.a_imag),
        .i_b_real   (in_ch.data.b_real),
        .i_b_imag   (in_ch.data.b_imag),
        .i_exponent (in_ch.data.exponent),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready),
        .o_res_real (out_ch.data.res_real),
        .o_res_imag (out_ch.data.res_imag),
        .o_status   (out_ch.data.status)
    );

    cau_checker i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .o_pending(pending_results),
        .o_errors (error_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result back-pressure: random stall bursts, one long hold-off early on.
    initial begin
        int cyc;
        int gap;
        bit held_off;
        cyc = 0;
        held_off = 0;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held_off && cyc > 3000) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                held_off = 1;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 6);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                cyc += gap;
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) begin
                    @(posedge i_clk);
                    cyc++;
                end
            end
        end
    end

    function automatic logic signed [15:0] pick_operand();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 16383)) - 8192);
            3:       return 16'($signed($urandom_range(0, 511)) - 256);
            4:       return '0;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_cau_req make_item(t_op op, int ar, int ai, int br, int bi,
                                           int ex);
        t_cau_req r;
        r.operation = op;
        r.a_real    = 16'(ar);
        r.a_imag    = 16'(ai);
        r.b_real    = 16'(br);
        r.b_imag    = 16'(bi);
        r.exponent  = 4'(ex);
        return r;
    endfunction

    // Offer one operand transfer, with an optional idle burst first.
    task automatic offer_item(t_cau_req req);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin
        t_cau_req directed[$];
        t_cau_req req;
        int       wait_cycles;
        cycle_count  = 0;
        quiet_phase  = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, saturation and each special case.
        directed.push_back(make_item(OP_ADD, 32767, -32768, 32767, -32768, 0));
        directed.push_back(make_item(OP_ADD, 100, -200, 300, 400, 15));
        directed.push_back(make_item(OP_SUB, 0, 0, -32768, -32768, 0));
        directed.push_back(make_item(OP_SUB, -32768, 32767, 32767, -32768, 5));
        directed.push_back(make_item(OP_MUL, -32768, -32768, -32768, -32768, 0));
        directed.push_back(make_item(OP_MUL, 4096, 2048, -4096, 6, 0));
        directed.push_back(make_item(OP_DIV, 1234, -567, 0, 0, 0));
        directed.push_back(make_item(OP_DIV, 4096, 4096, 4096, -4096, 0));
        directed.push_back(make_item(OP_DIV, 32767, -32768, 1, 0, 0));
        directed.push_back(make_item(OP_DIV, -32768, 32767, -1, -1, 0));
        directed.push_back(make_item(OP_CONJ, -32768, -32768, 5, 5, 0));
        directed.push_back(make_item(OP_CONJ, 32767, 32767, 0, 0, 9));
        directed.push_back(make_item(OP_ABS, -32768, -32768, 0, 0, 0));
        directed.push_back(make_item(OP_ABS, 0, 0, 1, 1, 0));
        directed.push_back(make_item(OP_ABS, 3, -4, 0, 0, 0));
        directed.push_back(make_item(OP_ARG, 0, 0, 7, 7, 0));
        directed.push_back(make_item(OP_ARG, -4096, 0, 0, 0, 0));
        directed.push_back(make_item(OP_ARG, -32768, -1, 0, 0, 0));
        directed.push_back(make_item(OP_ARG, 0, -32768, 0, 0, 0));
        directed.push_back(make_item(OP_ARG, 32767, 1, 0, 0, 0));
        directed.push_back(make_item(OP_POW, 32767, 32767, 3, 3, 0));
        directed.push_back(make_item(OP_POW, -4096, 100, 0, 0, 1));
        directed.push_back(make_item(OP_POW, 2900, 2900, 0, 0, 15));
        directed.push_back(make_item(OP_POW, -32768, -32768, 0, 0, 15));
        foreach (directed[i]) offer_item(directed[i]);

        // Random operands, with a share of small values, extremes and zero divisors.
        for (int n = 0; n < NumRandom; n++) begin
            if (n > NumRandom - 200) quiet_phase = 1;
            req.operation = t_op'($urandom_range(0, 7));
            req.a_real    = pick_operand();
            req.a_imag    = pick_operand();
            req.b_real    = pick_operand();
            req.b_imag    = pick_operand();
            req.exponent  = 4'($urandom_range(0, 15));
            if (req.operation == OP_DIV && $urandom_range(0, 9) == 0) begin
                req.b_real = '0;
                req.b_imag = '0;
            end
            offer_item(req);
        end
        in_ch.valid <= 1'b0;

        // Drain the pending results, then wait out a settle period before the verdict.
        while (pending_results != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 100) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (error_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_ctrl.sv
rtl/cau_dp.sv
rtl/complex_arithmetic_unit.sv
verif/tb_cau_pkg.sv
verif/cau_checker.sv
verif/tb_top.sv
